### hw/rtl/lock_order_checker_macros.svh
// Assertion macros for the lock order checker.
`ifndef LOCK_ORDER_CHECKER_MACROS_SVH
`define LOCK_ORDER_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF

`define LOC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lock order checker: check failed");

`define LOC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lock order checker: check failed");

`else

`define LOC_ASSERT(label, clk, rst_n, prop)

`define LOC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### hw/rtl/loc_pkg.sv
package loc_pkg;

    localparam int OPCODE_W = 2;
    localparam int CPU_W    = 4;
    localparam int CLASS_W  = 6;
    localparam int RANK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 32;

    localparam int DEF_MAX_CLASSES = 64;
    localparam int DEF_CPU_COUNT   = 4;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_RANK_BITS   = 16;

    localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACQUIRE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_VIOLATION = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEPTH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ORDER    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd3;

    typedef struct packed {
        logic capture;
        logic read_top_rank;
        logic commit;
    } loc_cmd_t;

endpackage

### hw/rtl/loc_ctrl.sv
module loc_ctrl
    import loc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output loc_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TOP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    always_comb
    begin
        slot_free      = !out_valid_reg || out_ready;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_TOP;
                end
            end
            S_TOP:
            begin
                cmd.read_top_rank = 1'b1;
                state_next        = S_EXEC;
            end
            S_EXEC:
            begin
                // hold the result until the out slot frees
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/loc_dp.sv
module loc_dp
    import loc_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int CPU_COUNT   = DEF_CPU_COUNT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int RANK_BITS   = DEF_RANK_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  loc_cmd_t            cmd,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CPU_W-1:0]    cpu,
    input  logic [CLASS_W-1:0]  class_id,
    input  logic [RANK_W-1:0]   rank,
    output logic [STATUS_W-1:0] status,
    output logic [CLASS_W-1:0]  assigned_class,
    output logic [KIND_W-1:0]   violation_kind,
    output logic [CLASS_W-1:0]  top_class,
    output logic [COUNT_W-1:0]  violation_count
);

    localparam int CLS_AW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int NC_W    = $clog2(MAX_CLASSES + 1);
    localparam int CPU_AW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int HOLD_N  = CPU_COUNT * STACK_DEPTH;
    localparam int HOLD_AW = (HOLD_N > 1) ? $clog2(HOLD_N) : 1;

    logic [RANK_BITS-1:0] rank_mem [MAX_CLASSES];
    logic [CLASS_W-1:0]   held_mem [HOLD_N];

    logic [CNT_W-1:0]     held_count_reg [CPU_COUNT];
    logic [NC_W-1:0]      next_class_reg;
    logic [COUNT_W-1:0]   total_reg;

    logic [OPCODE_W-1:0]  op_reg;
    logic [CPU_AW-1:0]    cpu_reg;
    logic [CLASS_W-1:0]   cls_reg;
    logic [RANK_BITS-1:0] new_rank_reg;
    logic [CLASS_W-1:0]   top_reg;
    logic [RANK_BITS-1:0] rank_rd_reg;
    logic [RANK_BITS-1:0] cls_rank_reg;

    logic [STATUS_W-1:0]  status_reg;
    logic [CLASS_W-1:0]   assigned_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [CLASS_W-1:0]   top_out_reg;

    logic [STATUS_W-1:0]  status_next;
    logic [CLASS_W-1:0]   assigned_next;
    logic [KIND_W-1:0]    kind_next;
    logic [CLASS_W-1:0]   top_out_next;

    logic [CPU_AW-1:0]    cpu_in;
    logic [CNT_W-1:0]     in_count;
    logic [HOLD_AW-1:0]   rd_addr;
    logic [HOLD_AW-1:0]   wr_addr;
    logic [CLS_AW-1:0]    rank_raddr;
    logic [CNT_W-1:0]     cnt;
    logic                 cls_known;
    logic                 top_known;
    logic                 reg_en;
    logic                 push_en;
    logic                 pop_en;

    assign cpu_in   = (32'(cpu) < CPU_COUNT) ? CPU_AW'(cpu) : '0;
    assign in_count = held_count_reg[cpu_in];
    assign rd_addr  = (in_count == '0) ? HOLD_AW'(32'(cpu_in) * STACK_DEPTH)
                    : HOLD_AW'(32'(cpu_in) * STACK_DEPTH + 32'(in_count) - 32'd1);

    assign cnt      = held_count_reg[cpu_reg];
    assign wr_addr  = HOLD_AW'(32'(cpu_reg) * STACK_DEPTH + 32'(cnt));

    assign rank_raddr = cmd.capture ? CLS_AW'(class_id) : CLS_AW'(top_reg);

    assign cls_known = (cls_reg != '0) && (32'(cls_reg) < 32'(next_class_reg));
    assign top_known = (top_reg != '0) && (32'(top_reg) < 32'(next_class_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            cpu_reg      <= cpu_in;
            cls_reg      <= class_id;
            new_rank_reg <= RANK_BITS'(rank);
            top_reg      <= held_mem[rd_addr];
        end
        if (cmd.commit && push_en)
        begin
            held_mem[wr_addr] <= cls_reg;
        end
    end

    // single read port: class rank on capture, top-class rank in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.capture || cmd.read_top_rank)
        begin
            rank_rd_reg <= rank_mem[rank_raddr];
        end
        if (cmd.read_top_rank)
        begin
            cls_rank_reg <= rank_rd_reg;
        end
        if (cmd.commit && reg_en)
        begin
            rank_mem[CLS_AW'(next_class_reg)] <= new_rank_reg;
        end
    end

    always_comb
    begin
        status_next   = STATUS_OK;
        assigned_next = '0;
        kind_next     = KIND_NONE;
        top_out_next  = '0;
        reg_en        = 1'b0;
        push_en       = 1'b0;
        pop_en        = 1'b0;
        unique case (op_reg)
            OP_REGISTER:
            begin
                if (32'(next_class_reg) >= MAX_CLASSES)
                begin
                    status_next = STATUS_INVALID;
                end
                else
                begin
                    reg_en        = 1'b1;
                    assigned_next = CLASS_W'(next_class_reg);
                end
            end
            OP_ACQUIRE, OP_RELEASE:
            begin
                if (cls_reg != '0)
                begin
                    if (!cls_known)
                    begin
                        status_next = STATUS_INVALID;
                    end
                    else if (op_reg == OP_ACQUIRE)
                    begin
                        if (32'(cnt) >= STACK_DEPTH)
                        begin
                            kind_next    = KIND_DEPTH;
                            top_out_next = top_reg;
                        end
                        else if (cnt != '0 && (!top_known || cls_rank_reg <= rank_rd_reg))
                        begin
                            kind_next    = KIND_ORDER;
                            top_out_next = top_reg;
                        end
                        else
                        begin
                            push_en = 1'b1;
                        end
                    end
                    else
                    begin
                        if (cnt == '0)
                        begin
                            kind_next = KIND_MISMATCH;
                        end
                        else if (top_reg != cls_reg)
                        begin
                            kind_next    = KIND_MISMATCH;
                            top_out_next = top_reg;
                        end
                        else
                        begin
                            pop_en = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                status_next = STATUS_INVALID;
            end
        endcase
        if (kind_next != KIND_NONE)
        begin
            status_next = STATUS_VIOLATION;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                held_count_reg[i] <= '0;
            end
            next_class_reg <= NC_W'(1);
            total_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            if (push_en)
            begin
                held_count_reg[cpu_reg] <= cnt + CNT_W'(1);
            end
            if (pop_en)
            begin
                held_count_reg[cpu_reg] <= cnt - CNT_W'(1);
            end
            if (reg_en)
            begin
                next_class_reg <= next_class_reg + NC_W'(1);
            end
            if (kind_next != KIND_NONE)
            begin
                total_reg <= total_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg   <= status_next;
            assigned_reg <= assigned_next;
            kind_reg     <= kind_next;
            top_out_reg  <= top_out_next;
        end
    end

    assign status          = status_reg;
    assign assigned_class  = assigned_reg;
    assign violation_kind  = kind_reg;
    assign top_class       = top_out_reg;
    assign violation_count = total_reg;

endmodule

### hw/rtl/lock_order_checker.sv
// Channel  Dir  Handshake            Fields
// in       in   in_valid/in_ready    opcode cpu class_id rank
// out      out  out_valid/out_ready  status assigned_class violation_kind top_class
//                                    violation_count
// A transaction runs from accept to result in steps: stack top and class rank are read
// on accept, the top-class rank next, then compare and commit.
// The single read port of the rank memory puts the two rank reads in separate steps.
// A new transaction is accepted while a finished result waits; commit holds until it is taken.
// Reset clears the class fill count, stack depths and violation total; no clearing pass.
`include "lock_order_checker_macros.svh"

module lock_order_checker
    import loc_pkg::*;
#(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int CPU_COUNT   = DEF_CPU_COUNT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int RANK_BITS   = DEF_RANK_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CPU_W-1:0]    cpu,
    input  logic [CLASS_W-1:0]  class_id,
    input  logic [RANK_W-1:0]   rank,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [CLASS_W-1:0]  assigned_class,
    output logic [KIND_W-1:0]   violation_kind,
    output logic [CLASS_W-1:0]  top_class,
    output logic [COUNT_W-1:0]  violation_count
);

    loc_cmd_t cmd;

    loc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    loc_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .CPU_COUNT   (CPU_COUNT),
        .STACK_DEPTH (STACK_DEPTH),
        .RANK_BITS   (RANK_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .opcode          (opcode),
        .cpu             (cpu),
        .class_id        (class_id),
        .rank            (rank),
        .status          (status),
        .assigned_class  (assigned_class),
        .violation_kind  (violation_kind),
        .top_class       (top_class),
        .violation_count (violation_count)
    );

    `LOC_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |-> (!out_valid && violation_count == 32'd0))
    `LOC_ASSERT(a_count_step, clk, rst_n, !$stable(violation_count) |-> (violation_count == $past(violation_count) + 32'd1))
    `LOC_ASSERT(a_count_flagged, clk, rst_n, !$stable(violation_count) |-> (out_valid && status == STATUS_VIOLATION))
    `LOC_ASSERT(a_kind_status, clk, rst_n, out_valid |-> ((violation_kind != KIND_NONE) == (status == STATUS_VIOLATION)))
    `LOC_ASSERT(a_assign_ok, clk, rst_n, (out_valid && assigned_class != 6'd0) |-> (status == STATUS_OK && violation_kind == KIND_NONE))

endmodule

### dv/lock_order_mirror.sv
module lock_order_mirror
    import loc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CPU_W-1:0]    cpu,
    input  logic [CLASS_W-1:0]  class_id,
    input  logic [RANK_W-1:0]   rank,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [CLASS_W-1:0]  assigned_class,
    input  logic [KIND_W-1:0]   violation_kind,
    input  logic [CLASS_W-1:0]  top_class,
    input  logic [COUNT_W-1:0]  violation_count,
    output int unsigned         mismatches,
    output int unsigned         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  assigned;
        logic [KIND_W-1:0]   kind;
        logic [CLASS_W-1:0]  top;
        logic [COUNT_W-1:0]  count;
    } lock_verdict_t;

    bit                       class_known [DEF_MAX_CLASSES];
    logic [DEF_RANK_BITS-1:0] class_rank_of [DEF_MAX_CLASSES];
    int unsigned              next_free_class;
    logic [CLASS_W-1:0]       lock_stack [DEF_CPU_COUNT][DEF_STACK_DEPTH];
    int unsigned              stack_fill [DEF_CPU_COUNT];
    logic [COUNT_W-1:0]       violations_seen;
    lock_verdict_t            verdicts [$];
    lock_verdict_t            want;

    function automatic lock_verdict_t judge_event(input logic [OPCODE_W-1:0] op,
                                                  input logic [CPU_W-1:0]    who,
                                                  input logic [CLASS_W-1:0]  cls,
                                                  input logic [RANK_W-1:0]   rk);
        lock_verdict_t      v;
        int unsigned        c;
        int unsigned        n;
        logic [CLASS_W-1:0] t;
        v = '0;
        c = (who < DEF_CPU_COUNT) ? who : 0;
        n = stack_fill[c];
        if (op == OP_REGISTER)
        begin
            if (next_free_class >= DEF_MAX_CLASSES)
                v.status = STATUS_INVALID;
            else
            begin
                class_known[next_free_class] = 1'b1;
                class_rank_of[next_free_class] = rk[DEF_RANK_BITS-1:0];
                v.assigned = CLASS_W'(next_free_class);
                next_free_class++;
            end
        end
        else if (op == OP_ACQUIRE || op == OP_RELEASE)
        begin
            if (cls != '0 && !class_known[cls])
                v.status = STATUS_INVALID;
            else if (cls != '0)
            begin
                t = (n != 0) ? lock_stack[c][n-1] : '0;
                if (op == OP_ACQUIRE)
                begin
                    if (n >= DEF_STACK_DEPTH)
                    begin
                        v.kind = KIND_DEPTH;
                        v.top = t;
                    end
                    else if (n != 0 && (!class_known[t] || class_rank_of[cls] <= class_rank_of[t]))
                    begin
                        v.kind = KIND_ORDER;
                        v.top = t;
                    end
                    else
                    begin
                        lock_stack[c][n] = cls;
                        stack_fill[c] = n + 1;
                    end
                end
                else if (n == 0 || t != cls)
                begin
                    v.kind = KIND_MISMATCH;
                    v.top = t;
                end
                else
                    stack_fill[c] = n - 1;
                if (v.kind != KIND_NONE)
                begin
                    v.status = STATUS_VIOLATION;
                    violations_seen = violations_seen + 1'b1;
                end
            end
        end
        else
            v.status = STATUS_INVALID;
        v.count = violations_seen;
        return v;
    endfunction

    function automatic void check_field(input string field, input logic [COUNT_W-1:0] exp_val,
                                        input logic [COUNT_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                     got_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (class_known[i])
                class_known[i] = 1'b0;
            foreach (stack_fill[i])
                stack_fill[i] = 0;
            next_free_class = 1;
            violations_seen = '0;
            verdicts.delete();
            mismatches = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                verdicts.push_back(judge_event(opcode, cpu, class_id, rank));
            if (out_valid && out_ready)
            begin
                if (verdicts.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual status %0d",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    check_field("status", COUNT_W'(want.status), COUNT_W'(status));
                    check_field("assigned_class", COUNT_W'(want.assigned),
                                COUNT_W'(assigned_class));
                    check_field("violation_kind", COUNT_W'(want.kind), COUNT_W'(violation_kind));
                    check_field("top_class", COUNT_W'(want.top), COUNT_W'(top_class));
                    check_field("violation_count", want.count, violation_count);
                end
            end
        end
        outstanding = verdicts.size();
    end

endmodule

### dv/lock_order_checker_tb.sv
module lock_order_checker_tb
    import loc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CPU_W-1:0]    cpu;
    logic [CLASS_W-1:0]  class_id;
    logic [RANK_W-1:0]   rank;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  assigned_class;
    logic [KIND_W-1:0]   violation_kind;
    logic [CLASS_W-1:0]  top_class;
    logic [COUNT_W-1:0]  violation_count;
    int unsigned         mismatches;
    int unsigned         outstanding;

    int unsigned         send_idle_pct;
    int unsigned         stall_pct;
    int unsigned         hold_requests;
    int unsigned         holds_done;
    int unsigned         items_sent;
    int unsigned         classes_made;
    logic [RANK_W-1:0]   rank_of [DEF_MAX_CLASSES];
    logic [CLASS_W-1:0]  held_now [DEF_CPU_COUNT][$];

    int unsigned idle_by_phase [4] = '{0, 48, 0, 9};
    int unsigned stall_by_phase [4] = '{0, 0, 48, 9};

    lock_order_checker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .cpu             (cpu),
        .class_id        (class_id),
        .rank            (rank),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .assigned_class  (assigned_class),
        .violation_kind  (violation_kind),
        .top_class       (top_class),
        .violation_count (violation_count)
    );

    lock_order_mirror mirror (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .cpu             (cpu),
        .class_id        (class_id),
        .rank            (rank),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .assigned_class  (assigned_class),
        .violation_kind  (violation_kind),
        .top_class       (top_class),
        .violation_count (violation_count),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // hold off for a long stretch on request, else stall at random
    initial
    begin
        out_ready = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [CPU_W-1:0] who,
                         input logic [CLASS_W-1:0] cls, input logic [RANK_W-1:0] rk);
        int unsigned c;
        c = (who < DEF_CPU_COUNT) ? who : 0;
        case (op)
            OP_REGISTER:
                if (classes_made < DEF_MAX_CLASSES - 1)
                begin
                    classes_made++;
                    rank_of[classes_made] = rk;
                end
            OP_ACQUIRE:
                if (cls != '0 && cls <= classes_made && held_now[c].size() < DEF_STACK_DEPTH
                    && (held_now[c].size() == 0 || rank_of[cls] > rank_of[held_now[c][$]]))
                    held_now[c].push_back(cls);
            OP_RELEASE:
                if (cls != '0 && held_now[c].size() != 0 && held_now[c][$] == cls)
                    void'(held_now[c].pop_back());
            default:
                ;
        endcase
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        opcode <= op;
        cpu <= who;
        class_id <= cls;
        rank <= rk;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic maybe_noise();
        if ($urandom_range(99) < 12)
            issue(OPCODE_W'($urandom_range(3)), CPU_W'($urandom), CLASS_W'($urandom),
                  RANK_W'($urandom));
    endtask

    // push a rank-ordered chain on one cpu, then unwind its stack in part, in full or not at all
    task automatic run_episode();
        logic [CPU_W-1:0]   who;
        int unsigned        c;
        int unsigned        base;
        int unsigned        want;
        int unsigned        stop;
        int unsigned        pick;
        logic [CLASS_W-1:0] pool [$];
        logic [CLASS_W-1:0] chain [$];
        logic [RANK_W-1:0]  floor_rank;
        if (classes_made < 24 || $urandom_range(2) == 0)
            issue(OP_REGISTER, CPU_W'($urandom), CLASS_W'($urandom),
                  ($urandom_range(9) == 0) ? rank_of[$urandom_range(1, classes_made)]
                                           : RANK_W'($urandom));
        who = CPU_W'($urandom);
        c = (who < DEF_CPU_COUNT) ? who : 0;
        base = held_now[c].size();
        floor_rank = (base != 0) ? rank_of[held_now[c][base-1]] : '0;
        for (int id = 1; id <= classes_made; id++)
            if (base == 0 || rank_of[id] > floor_rank)
                pool.push_back(CLASS_W'(id));
        pool.shuffle();
        want = ($urandom_range(3) == 0) ? DEF_STACK_DEPTH + 2 : $urandom_range(1, 6);
        while (pool.size() > want)
            void'(pool.pop_back());
        pool.sort with (rank_of[item]);
        foreach (pool[i])
            if (chain.size() == 0 || rank_of[pool[i]] > rank_of[chain[$]])
                chain.push_back(pool[i]);
        foreach (chain[i])
        begin
            maybe_noise();
            issue(OP_ACQUIRE, who, chain[i], RANK_W'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 60)
            stop = 0;
        else if (pick < 85)
            stop = base;
        else
            stop = $urandom_range(0, held_now[c].size());
        while (held_now[c].size() > stop)
        begin
            maybe_noise();
            if (held_now[c].size() > stop)
                issue(OP_RELEASE, who, held_now[c][$], RANK_W'($urandom));
        end
    endtask

    initial
    begin
        int unsigned start;
        int unsigned phase;
        int unsigned last_phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_REGISTER;
        cpu = '0;
        class_id = '0;
        rank = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        items_sent = 0;
        classes_made = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        issue(OP_ACQUIRE, 4'd0, 6'd5, 16'h0000);
        issue(OP_RELEASE, 4'd1, 6'd0, 16'h0000);
        issue(OP_UNUSED, 4'd15, 6'd63, 16'hffff);
        issue(OP_REGISTER, 4'd15, 6'd63, 16'h0000);
        issue(OP_REGISTER, 4'd0, 6'd0, 16'hffff);
        issue(OP_REGISTER, 4'd3, 6'd1, 16'h1234);
        issue(OP_REGISTER, 4'd7, 6'd2, 16'h1234);
        issue(OP_REGISTER, 4'd2, 6'd9, 16'h8000);
        issue(OP_RELEASE, 4'd2, 6'd1, 16'h0000);
        issue(OP_ACQUIRE, 4'd15, 6'd1, 16'hffff);
        issue(OP_ACQUIRE, 4'd0, 6'd3, 16'h0000);
        issue(OP_ACQUIRE, 4'd4, 6'd4, 16'h0000);
        issue(OP_ACQUIRE, 4'd0, 6'd1, 16'h0000);
        issue(OP_ACQUIRE, 4'd0, 6'd5, 16'h0000);
        issue(OP_ACQUIRE, 4'd8, 6'd2, 16'h0000);
        issue(OP_RELEASE, 4'd0, 6'd5, 16'h0000);
        issue(OP_RELEASE, 4'd0, 6'd2, 16'h0000);
        issue(OP_RELEASE, 4'd12, 6'd5, 16'h0000);
        issue(OP_RELEASE, 4'd0, 6'd3, 16'h0000);
        issue(OP_RELEASE, 4'd0, 6'd1, 16'h0000);
        issue(OP_ACQUIRE, 4'd3, 6'd0, 16'hffff);
        issue(OP_ACQUIRE, 4'd3, 6'd63, 16'hffff);

        start = items_sent;
        last_phase = 4;
        while (items_sent < start + RANDOM_ITEMS)
        begin
            phase = (items_sent - start) * 4 / RANDOM_ITEMS;
            if (phase != last_phase)
            begin
                last_phase = phase;
                send_idle_pct = idle_by_phase[phase];
                stall_pct = stall_by_phase[phase];
                hold_requests++;
            end
            run_episode();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/loc_pkg.sv
hw/rtl/loc_ctrl.sv
hw/rtl/loc_dp.sv
hw/rtl/lock_order_checker.sv
dv/lock_order_mirror.sv
dv/lock_order_checker_tb.sv
